// ===== rtl/pdd_pkg.sv =====
// Package for the peak deviation decimator.
// Holds the Q8.8/Q10.8 widths, the control state type and the edge reload helper.
// No dependencies.
package pdd_pkg;

    localparam int LEN_W  = 16;   // window length register, unsigned Q8.8
    localparam int EDGE_W = 18;   // signed Q10.8 distance to the window edge

    localparam logic [LEN_W-1:0] ONE_Q8 = LEN_W'(256);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Reload value of the edge distance: effective length minus one sample.
    // Lengths below 1.0 act as 1.0.
    function automatic logic signed [EDGE_W-1:0] edge_reload(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] diff;
        diff = (len < ONE_Q8) ? '0 : (len - ONE_Q8);
        return $signed({{(EDGE_W-LEN_W){1'b0}}, diff});
    endfunction

endpackage

// ===== rtl/pdd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pdd_scan.sv =====
// Window scan unit: walks the stored samples of a closed window and keeps the
// one with the largest |count*x - sum|. Three stages: read, multiply, compare.
// Depends on pdd_pkg (imported for house consistency).
module pdd_scan #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]            i_count,
    input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW):0] i_sum,
    output logic [$clog2(MAX_WINDOW)-1:0]              o_raddr,
    input  logic signed [SAMPLE_BITS-1:0]              i_rdata,
    output logic                                       o_done,
    output logic signed [SAMPLE_BITS-1:0]              o_peak
);
    import pdd_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_WINDOW);
    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int PROD_W  = SAMPLE_BITS + COUNT_W + 1;
    localparam int DEV_W   = PROD_W + 1;

    logic                     r_issue;
    logic [ADDR_W-1:0]        r_addr;
    logic [ADDR_W-1:0]        r_last_addr;
    logic [COUNT_W-1:0]       r_n;
    logic signed [SUM_W-1:0]  r_sum;

    logic                     r_v1, r_first1, r_end1;
    logic                     r_v2, r_first2, r_end2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SAMPLE_BITS-1:0] r_x2;

    logic [DEV_W-1:0]         r_best_dev;
    logic signed [SAMPLE_BITS-1:0] r_best;
    logic                     r_done;

    logic signed [DEV_W-1:0]  w_diff;
    logic [DEV_W-1:0]         w_dev;

    assign o_raddr = r_addr;

    // Issue stage: one address per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            if (i_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_addr == r_last_addr)) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_addr == '0);
        r_end1   <= (r_addr == r_last_addr);
        if (i_start) begin
            r_addr      <= '0;
            r_last_addr <= ADDR_W'(i_count - COUNT_W'(1));
            r_n         <= i_count;
            r_sum       <= i_sum;
        end else if (r_issue) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first2 <= r_first1;
        r_end2   <= r_end1;
        r_prod   <= $signed({1'b0, r_n}) * i_rdata;
        r_x2     <= i_rdata;
    end

    // Compare stage: strict greater keeps the earliest sample on a tie
    assign w_diff = DEV_W'(r_prod) - DEV_W'(r_sum);
    assign w_dev  = w_diff[DEV_W-1] ? DEV_W'(-w_diff) : DEV_W'(w_diff);

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            if (r_first2 || (w_dev > r_best_dev)) begin
                r_best_dev <= w_dev;
                r_best     <= r_x2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v2 && r_end2;
        end
    end

    assign o_done = r_done;
    assign o_peak = r_best;

endmodule

// ===== rtl/peak_deviation_decimator.sv =====
// Peak deviation decimator: splits the sample stream into windows of a Q8.8
// length and returns, per window, the stored sample furthest from the window
// mean. An item that does not close a window is taken without a stall. An
// item that closes a window keeps the input stalled while the window memory
// is read one sample per cycle through its single read port into a multiply
// and compare pipeline (an empty window skips this), and until the result
// enters the output register. A finished result sits there while the next
// item is already taken. Depends on pdd_pkg, pdd_ram and pdd_scan.
module peak_deviation_decimator #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pdd_pkg::LEN_W-1:0]     i_cfg_window_length_q8,
    // sample input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_is_valid,
    input  logic                          i_end_of_stream,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value,
    output logic                          o_window_empty,
    output logic                          o_last_window
);
    import pdd_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_WINDOW);
    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;

    t_state r_state, n_state;

    logic [LEN_W-1:0]              r_len;
    logic signed [EDGE_W-1:0]      r_edge, n_edge;
    logic [COUNT_W-1:0]            r_count, n_count;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic                          r_res_empty, r_res_last;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_peak;
    logic                          r_empty, r_last;

    logic w_in_xfer, w_cfg_xfer, w_store, w_close, w_start;
    logic w_in_ready, w_load_out;
    logic signed [EDGE_W-1:0]      w_reload;
    logic [ADDR_W-1:0]             w_raddr;
    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic                          w_scan_done;
    logic signed [SAMPLE_BITS-1:0] w_scan_peak;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid;
    assign w_in_xfer   = i_in_valid && w_in_ready;

    assign w_store  = i_is_valid && (r_count < COUNT_W'(MAX_WINDOW));
    assign n_count  = r_count + COUNT_W'(w_store);
    assign n_sum    = r_sum + (w_store ? SUM_W'(i_sample) : SUM_W'(0));
    assign w_close  = (r_edge <= 0) || i_end_of_stream;
    assign w_start  = w_in_xfer && w_close && (n_count != '0);
    assign w_reload = edge_reload(r_len);

    always_comb begin
        if (i_end_of_stream) begin
            n_edge = w_reload;
        end else if (r_edge <= 0) begin
            n_edge = r_edge + w_reload;
        end else begin
            n_edge = r_edge - $signed({{(EDGE_W-LEN_W){1'b0}}, ONE_Q8});
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && w_close) begin
                    n_state = (n_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_SCAN: w_in_ready = 1'b0;
            ST_DONE: w_load_out = !r_out_valid || i_out_ready;
            default: w_in_ready = 1'b0;
        endcase
    end

    assign o_in_ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= ONE_Q8;
            r_edge      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_xfer) begin
                r_len  <= i_cfg_window_length_q8;
                r_edge <= edge_reload(i_cfg_window_length_q8);
            end else if (w_in_xfer) begin
                r_edge <= n_edge;
            end
            if (w_in_xfer) begin
                r_count <= w_close ? '0 : n_count;
                r_sum   <= w_close ? '0 : n_sum;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_close) begin
            r_res_empty <= (n_count == '0);
            r_res_last  <= i_end_of_stream;
        end
        if (w_load_out) begin
            r_peak  <= r_res_empty ? '0 : w_scan_peak;
            r_empty <= r_res_empty;
            r_last  <= r_res_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_peak_value   = r_peak;
    assign o_window_empty = r_empty;
    assign o_last_window  = r_last;

    pdd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_xfer && w_store),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pdd_scan #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_count (n_count),
        .i_sum   (n_sum),
        .o_raddr (w_raddr),
        .i_rdata ($signed(w_rdata)),
        .o_done  (w_scan_done),
        .o_peak  (w_scan_peak)
    );

endmodule

// ===== rtl/pdd_checker.sv =====
// Port-level checks for the peak deviation decimator, bound to the top level.
// Depends on peak_deviation_decimator ports only.
module pdd_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          i_in_valid,
    input logic                          i_end_of_stream,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_peak_value,
    input logic                          o_window_empty,
    input logic                          o_last_window
);

    // A held result keeps its peak value and last-window flag until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_peak_value)
            && $stable(o_last_window))
        else $error("result dropped or changed while stalled");

    // An empty window always reports zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_window_empty |-> o_peak_value == '0)
        else $error("empty window with non-zero peak");

    // End of stream always closes a window, so input stalls afterwards
    a_eos_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_stream |=> !o_in_ready)
        else $error("input taken straight after end of stream");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind peak_deviation_decimator pdd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pdd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .i_in_valid      (i_in_valid),
    .i_end_of_stream (i_end_of_stream),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_peak_value    (o_peak_value),
    .o_window_empty  (o_window_empty),
    .o_last_window   (o_last_window)
);
